// ===== rtl/xdkc_pkg.sv =====
// Package for the XOR-distance k-closest block: item types, opcodes,
// register indexes and size constants. No dependencies.
`default_nettype none
package xdkc_pkg;

    localparam int DEF_MAX_K  = 16;
    localparam int ID_BYTES   = 32;
    localparam int WORD_W     = 64;
    localparam int DIST_W     = ID_BYTES * 8;
    localparam int CFG_IDX_W  = 3;
    localparam int LIMIT_W    = 5;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_OFFER = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET3 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT   = 3'd4;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [WORD_W-1:0] peer_word0;
        logic [WORD_W-1:0] peer_word1;
        logic [WORD_W-1:0] peer_word2;
        logic [WORD_W-1:0] peer_word3;
        logic [15:0]       peer_handle;
        logic              self_peer;
    } t_item;

    typedef struct packed {
        logic [3:0]  rank;
        logic [15:0] closest_handle;
        logic [4:0]  found_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic  vld;
        t_item item;
    } t_queue_head;

endpackage
`default_nettype wire

// ===== rtl/xor_distance_k_closest_top.sv =====
// Top level of the XOR-distance k-closest list: front queue and back end.
// Depends on xdkc_pkg, xdkc_front and xdkc_back.
//
//  channel   ports                              handshake
//  item in   i_start, i_item, o_busy            taken when i_start && !o_busy
//  result    o_valid, o_result                  one cycle strobe, no stall
//  config    i_cfg_we, i_cfg_idx, i_cfg_data    written when i_cfg_we
//
// Start and offer are handled in the back end as the head is popped; an offer
// compares against all K slots at once and shifts the row in the same cycle.
// A read emits max(1, n) results, one result per cycle, n = min(count, K).
// o_busy rises when the two-entry queue is full, mostly behind a read.
// Synchronous reset clears the list, the queue and the registers.
`default_nettype none
module xor_distance_k_closest_top #(
    parameter int MAX_K = xdkc_pkg::DEF_MAX_K
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_start,
    input  xdkc_pkg::t_item               i_item,
    output logic                          o_busy,
    input  wire                           i_cfg_we,
    input  wire [xdkc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire [xdkc_pkg::WORD_W-1:0]    i_cfg_data,
    output logic                          o_valid,
    output xdkc_pkg::t_result             o_result
);
    import xdkc_pkg::*;

    t_queue_head head;
    logic        pop;
    logic        full;

    xdkc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_start && !full),
        .i_item  (i_item),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (full)
    );

    xdkc_back #(.MAX_K(MAX_K)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (head),
        .o_pop      (pop),
        .o_valid    (o_valid),
        .o_result   (o_result)
    );

    assign o_busy = full;

`ifndef ASSERT_OFF
    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result strobe right after reset");
    a_stream: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_result.last) |=> o_valid)
        else $error("read-out stream broken");
    a_first_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !($past(o_valid) && !$past(o_result.last))) |-> o_result.rank == 4'd0)
        else $error("read-out does not begin at rank zero");
`endif

endmodule
`default_nettype wire

// ===== rtl/xdkc_front.sv =====
// Front end: accepts items into a two-entry queue and hands the head
// to the back end. Depends on xdkc_pkg.
`default_nettype none
module xdkc_front (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  xdkc_pkg::t_item      i_item,
    input  wire                  i_pop,
    output xdkc_pkg::t_queue_head o_head,
    output logic                 o_full
);
    import xdkc_pkg::*;

    t_item      r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 2'd1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_item;
        end
    end

    assign o_head.vld  = (r_cnt != 2'd0);
    assign o_head.item = r_q[r_rp];
    assign o_full      = (r_cnt == 2'd2);

endmodule
`default_nettype wire

// ===== rtl/xdkc_back.sv =====
// Back end: configuration registers, sorted compare-and-shift row of
// distances and handles, and the read-out sequencer. Depends on xdkc_pkg.
`default_nettype none
module xdkc_back #(
    parameter int MAX_K = xdkc_pkg::DEF_MAX_K
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_cfg_we,
    input  wire [xdkc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire [xdkc_pkg::WORD_W-1:0]       i_cfg_data,
    input  xdkc_pkg::t_queue_head            i_head,
    output logic                             o_pop,
    output logic                             o_valid,
    output xdkc_pkg::t_result                o_result
);
    import xdkc_pkg::*;

    localparam int CW = $clog2(MAX_K + 1);

    logic [WORD_W-1:0]  r_tgt [4];
    logic [LIMIT_W-1:0] r_limit;
    logic [DIST_W-1:0]  r_dist [MAX_K];
    logic [15:0]        r_hnd [MAX_K];
    logic [MAX_K-1:0]   r_vld;
    logic [CW-1:0]      r_count;
    logic               r_rd_act;
    logic [CW-1:0]      r_rd_idx;
    logic [CW-1:0]      r_rd_n;
    logic               r_ostb;
    t_result            r_out;

    logic [CW-1:0]      k;
    logic [CW-1:0]      n;
    logic [DIST_W-1:0]  dnew;
    logic [MAX_K-1:0]   lt;
    logic [MAX_K-1:0]   is_pos;
    logic [MAX_K-1:0]   below;
    logic               found;
    logic               do_offer;
    t_item              it;

    assign it    = i_head.item;
    assign o_pop = i_head.vld && !r_rd_act;
    assign k     = (int'(r_limit) > MAX_K) ? CW'(MAX_K) : CW'(r_limit);
    assign n     = (r_count < k) ? r_count : k;
    assign dnew  = {r_tgt[0] ^ it.peer_word0, r_tgt[1] ^ it.peer_word1,
                    r_tgt[2] ^ it.peer_word2, r_tgt[3] ^ it.peer_word3};

    always_comb begin
        found = 1'b0;
        for (int i = 0; i < MAX_K; i++) begin
            lt[i]     = (i < int'(k)) && (dnew < (r_vld[i] ? r_dist[i] : {DIST_W{1'b1}}));
            below[i]  = found;
            is_pos[i] = lt[i] && !found;
            found     = found | lt[i];
        end
    end

    assign do_offer = o_pop && (it.opcode == OP_OFFER) && !it.self_peer && found;

    always_ff @(posedge i_clk) begin
        if (do_offer) begin
            for (int j = 0; j < MAX_K; j++) begin
                if (is_pos[j]) begin
                    r_dist[j] <= dnew;
                    r_hnd[j]  <= it.peer_handle;
                end else if (j > 0 && below[j] && j < int'(k)) begin
                    r_dist[j] <= r_dist[(j > 0) ? j - 1 : 0];
                    r_hnd[j]  <= r_hnd[(j > 0) ? j - 1 : 0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt[0] <= '0;
            r_tgt[1] <= '0;
            r_tgt[2] <= '0;
            r_tgt[3] <= '0;
            r_limit  <= LIMIT_RESET;
            r_vld    <= '0;
            r_count  <= '0;
            r_rd_act <= 1'b0;
            r_rd_idx <= '0;
            r_rd_n   <= '0;
            r_ostb   <= 1'b0;
            r_out    <= '0;
        end else begin
            r_ostb <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET0: r_tgt[0] <= i_cfg_data;
                    REG_TARGET1: r_tgt[1] <= i_cfg_data;
                    REG_TARGET2: r_tgt[2] <= i_cfg_data;
                    REG_TARGET3: r_tgt[3] <= i_cfg_data;
                    REG_LIMIT:   r_limit  <= i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (r_rd_act) begin
                r_ostb                <= 1'b1;
                r_out.rank            <= 4'(r_rd_idx);
                r_out.closest_handle  <= r_hnd[r_rd_idx[$clog2(MAX_K > 1 ? MAX_K : 2)-1:0]];
                r_out.found_count     <= 5'(r_rd_n);
                r_out.last            <= (r_rd_idx + CW'(1) == r_rd_n);
                r_rd_idx              <= r_rd_idx + CW'(1);
                if (r_rd_idx + CW'(1) == r_rd_n) begin
                    r_rd_act <= 1'b0;
                end
            end else if (o_pop) begin
                case (it.opcode)
                    OP_START: begin
                        r_vld   <= '0;
                        r_count <= '0;
                    end
                    OP_OFFER: begin
                        if (do_offer) begin
                            for (int j = 0; j < MAX_K; j++) begin
                                if (is_pos[j] || (below[j] && j < int'(k))) begin
                                    r_vld[j] <= (is_pos[j] || r_vld[(j > 0) ? j - 1 : 0]);
                                end
                            end
                            if (r_count < k) begin
                                r_count <= r_count + CW'(1);
                            end
                        end
                    end
                    OP_READ: begin
                        r_ostb               <= 1'b1;
                        r_out.rank           <= 4'd0;
                        r_out.found_count    <= 5'(n);
                        r_out.last           <= (n <= CW'(1));
                        r_out.closest_handle <= (n == '0) ? 16'd0 : r_hnd[0];
                        r_rd_n               <= n;
                        r_rd_idx             <= CW'(1);
                        r_rd_act             <= (n > CW'(1));
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_valid  = r_ostb;
    assign o_result = r_out;

endmodule
`default_nettype wire

// ===== dv/xdkc_checker.sv =====
// Checker for the XOR-distance k-closest list: watches the item, config and result
// channels, predicts each read out and compares it with what the block emits.
// Depends on xdkc_pkg.
module xdkc_checker
    import xdkc_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_busy,
    input  t_item                i_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WORD_W-1:0]    i_cfg_data,
    input  logic                 i_valid,
    input  t_result              i_result,
    output int                   o_fail_count,
    output int                   o_pending
);

    logic [DIST_W-1:0] dist_row [DEF_MAX_K];
    logic [15:0]       handle_row [DEF_MAX_K];
    logic [4:0]        peer_count;
    logic [DIST_W-1:0] tgt_digest;
    logic [4:0]        keep_limit;
    t_result           readout_q [$];

    initial o_fail_count = 0;

    function automatic int keep_k();
        return (keep_limit > DEF_MAX_K) ? DEF_MAX_K : int'(keep_limit);
    endfunction

    task automatic report(string what, t_result exp_r, t_result act_r);
        o_fail_count++;
        if (o_fail_count <= 10) begin
            $display("mismatch (%s): expected rank %0d handle %h count %0d last %b,",
                what, exp_r.rank, exp_r.closest_handle, exp_r.found_count, exp_r.last);
            $display("    got rank %0d handle %h count %0d last %b",
                act_r.rank, act_r.closest_handle, act_r.found_count, act_r.last);
        end
    endtask

    task automatic predict_item(t_item it);
        logic [DIST_W-1:0] d;
        int                k;
        int                n;
        bit                placed;
        t_result           r;
        k = keep_k();
        case (it.opcode)
            OP_START: begin
                for (int i = 0; i < DEF_MAX_K; i++) dist_row[i] = '1;
                peer_count = '0;
            end
            OP_OFFER: begin
                if (!it.self_peer) begin
                    d = tgt_digest ^ {it.peer_word0, it.peer_word1,
                                      it.peer_word2, it.peer_word3};
                    placed = 1'b0;
                    for (int i = 0; i < k && !placed; i++) begin
                        if (d < dist_row[i]) begin
                            for (int j = k - 1; j > i; j--) begin
                                dist_row[j]   = dist_row[j-1];
                                handle_row[j] = handle_row[j-1];
                            end
                            dist_row[i]   = d;
                            handle_row[i] = it.peer_handle;
                            if (peer_count < k) peer_count++;
                            placed = 1'b1;
                        end
                    end
                end
            end
            OP_READ: begin
                n = (int'(peer_count) < k) ? int'(peer_count) : k;
                if (n == 0) begin
                    r = '0;
                    r.last = 1'b1;
                    readout_q.push_back(r);
                end
                for (int i = 0; i < n; i++) begin
                    r.rank           = i[3:0];
                    r.closest_handle = handle_row[i];
                    r.found_count    = n[4:0];
                    r.last           = (i + 1 == n);
                    readout_q.push_back(r);
                end
            end
            default: ;
        endcase
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < DEF_MAX_K; i++) begin
                dist_row[i]   = '1;
                handle_row[i] = '0;
            end
            peer_count = '0;
            tgt_digest = '0;
            keep_limit = LIMIT_RESET;
            readout_q.delete();
        end else begin
            if (i_valid) begin
                if (readout_q.size() == 0) begin
                    report("unexpected", '0, i_result);
                end else begin
                    if (i_result.rank != readout_q[0].rank ||
                        i_result.closest_handle != readout_q[0].closest_handle ||
                        i_result.found_count != readout_q[0].found_count ||
                        i_result.last != readout_q[0].last) begin
                        report("field", readout_q[0], i_result);
                    end
                    void'(readout_q.pop_front());
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_TARGET0: tgt_digest[255:192] = i_cfg_data;
                    REG_TARGET1: tgt_digest[191:128] = i_cfg_data;
                    REG_TARGET2: tgt_digest[127:64]  = i_cfg_data;
                    REG_TARGET3: tgt_digest[63:0]    = i_cfg_data;
                    REG_LIMIT:   keep_limit          = i_cfg_data[LIMIT_W-1:0];
                    default: ;
                endcase
            end
            if (i_start && !i_busy) predict_item(i_item);
        end
        o_pending = readout_q.size();
    end

endmodule

// ===== dv/tb_top.sv =====
// Top of the XOR-distance k-closest testbench: clock, reset, item and config
// stimulus, and the verdict. Depends on xdkc_pkg, xor_distance_k_closest_top, xdkc_checker.
module tb_top;
    import xdkc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_start = 1'b0;
    t_item                i_item = '0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [WORD_W-1:0]    i_cfg_data = '0;
    logic                 o_busy;
    logic                 o_valid;
    t_result              o_result;
    int                   fail_count;
    int                   pending;
    int                   cycle_count = 0;
    int                   idle_pct = 0;
    int                   sent = 0;
    logic [DIST_W-1:0]    target_tb = '0;
    logic [DIST_W-1:0]    last_peer = '0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    xor_distance_k_closest_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_item(i_item),
        .o_busy(o_busy), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .o_valid(o_valid), .o_result(o_result)
    );

    xdkc_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .i_busy(o_busy),
        .i_item(i_item), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data), .i_valid(o_valid), .i_result(o_result),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    function automatic t_item make_item(logic [1:0] op, logic [DIST_W-1:0] peer,
                                        logic [15:0] hnd, logic loc);
        t_item it;
        it.opcode      = op;
        it.peer_word0  = peer[255:192];
        it.peer_word1  = peer[191:128];
        it.peer_word2  = peer[127:64];
        it.peer_word3  = peer[63:0];
        it.peer_handle = hnd;
        it.self_peer   = loc;
        return it;
    endfunction

    function automatic logic [DIST_W-1:0] pick_peer();
        logic [DIST_W-1:0] p;
        case ($urandom_range(9))
            0: p = ~target_tb;
            1: p = last_peer;
            2: p = target_tb ^ DIST_W'($urandom_range(255));
            3: p = target_tb;
            4: p = target_tb ^ {rand64(), 192'd0};
            default: p = {rand64(), rand64(), rand64(), rand64()};
        endcase
        return p;
    endfunction

    task automatic send(t_item it);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_item  <= it;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
        sent++;
    endtask

    task automatic send_offer();
        logic [DIST_W-1:0] p;
        p = pick_peer();
        send(make_item(OP_OFFER, p, 16'($urandom()), $urandom_range(9) == 0));
        last_peer = p;
    endtask

    task automatic settle();
        i_start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_config(logic [4:0] lim);
        case ($urandom_range(3))
            0: target_tb = '0;
            1: target_tb = '1;
            default: target_tb = {rand64(), rand64(), rand64(), rand64()};
        endcase
        for (int w = 0; w < 4; w++) begin
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= CFG_IDX_W'(w);
            i_cfg_data <= target_tb[255 - 64*w -: 64];
            @(posedge i_clk);
        end
        i_cfg_idx  <= REG_LIMIT;
        i_cfg_data <= {59'd0, lim};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        logic [4:0] limits [7];
        int         budget;
        int         offers;
        limits = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd5, 5'd16, 5'd3};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send(make_item(OP_READ, '0, '0, 1'b0));
        send(make_item(OP_OFFER, '1, 16'hFFFF, 1'b0));
        send(make_item(OP_OFFER, '0, 16'hFFFF, 1'b0));
        send(make_item(OP_OFFER, '0, 16'h1234, 1'b0));
        send(make_item(OP_OFFER, {255'd0, 1'b1}, 16'h0000, 1'b1));
        send(make_item(2'd3, '1, 16'hFFFF, 1'b1));
        send(make_item(OP_OFFER, {1'b0, {255{1'b1}}}, 16'hA5A5, 1'b0));
        send(make_item(OP_OFFER, {255'd0, 1'b1}, 16'h5A5A, 1'b0));
        send(make_item(OP_READ, '1, '1, 1'b1));
        send(make_item(OP_START, '1, '1, 1'b1));
        send(make_item(OP_READ, '0, '0, 1'b0));

        for (int ph = 0; ph < 7; ph++) begin
            settle();
            write_config(limits[ph]);
            case (ph % 4)
                1:       idle_pct = 54;
                3:       idle_pct = 24;
                default: idle_pct = 0;
            endcase
            budget = sent + 38;
            while (sent < budget) begin
                if ($urandom_range(9) == 0) begin
                    send(make_item(2'($urandom_range(3)),
                                   {rand64(), rand64(), rand64(), rand64()},
                                   16'($urandom()), 1'($urandom())));
                end else begin
                    if ($urandom_range(4) != 0) send(make_item(OP_START, '0, '0, 1'b0));
                    offers = $urandom_range(1, 20);
                    repeat (offers) send_offer();
                    send(make_item(OP_READ, '0, '0, 1'b0));
                end
            end
        end

        i_start <= 1'b0;
        @(posedge i_clk);
        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
